>>> rtl/core/assert_macros.svh
// Assertion macros used by the checker module of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property that is switched off while reset is active.
`define ASSERT_CLKD(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed");

// Clocked property that is also checked during reset.
`define ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) (prop)) \
    else $error("assertion failed");

`endif

>>> rtl/core/ntb_pkg.sv
// Types, constants and field layouts of the named timer bank.
`timescale 1ns / 1ps
`default_nettype none

package ntb_pkg;

  localparam int unsigned NumTimersDefault = 8;
  localparam int unsigned IdW      = 16;
  localparam int unsigned TimeW    = 32;
  localparam int unsigned DeltaW   = 31;
  localparam int unsigned FuncW    = 2;
  localparam int unsigned KindW    = 2;
  localparam int unsigned StatusW  = 3;
  localparam int unsigned InDataW  = 152;
  localparam int unsigned OutDataW = 120;

  localparam int unsigned QueueDepth = 2;
  localparam int unsigned QueuePtrW  = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int unsigned QueueCntW  = $clog2(QueueDepth + 1);

  typedef enum logic [FuncW-1:0] {
    FuncAdd  = 2'd0,
    FuncGet  = 2'd1,
    FuncTick = 2'd2
  } func_e;

  typedef enum logic [KindW-1:0] {
    KindAdd    = 2'd0,
    KindGet    = 2'd1,
    KindExpiry = 2'd2
  } kind_e;

  typedef enum logic [StatusW-1:0] {
    StAdded    = 3'd0,
    StDup      = 3'd1,
    StFull     = 3'd2,
    StFound    = 3'd3,
    StNotFound = 3'd4
  } status_e;

  typedef struct packed {
    func_e              op;
    logic [IdW-1:0]     id;
    logic               dir;
    logic [TimeW-1:0]   init_time;
    logic [TimeW-1:0]   reload_time;
    logic [TimeW-1:0]   goal_time;
    logic               en;
    logic               one;
    logic [DeltaW-1:0]  delta;
  } cmd_t;

  typedef struct packed {
    logic [IdW-1:0]   id;
    logic             dir;
    logic             en;
    logic             one;
    logic [TimeW-1:0] cur;
    logic [TimeW-1:0] reload;
    logic [TimeW-1:0] goal;
  } slot_t;

  typedef struct packed {
    kind_e            kind;
    status_e          status;
    logic [IdW-1:0]   id;
    logic             dir;
    logic [TimeW-1:0] cur;
    logic [TimeW-1:0] reload;
    logic [TimeW-1:0] goal;
    logic             en;
    logic             one;
    logic             last;
  } result_t;

endpackage

`default_nettype wire

>>> rtl/core/named_timer_bank_core.sv
// Commands are worked one at a time: the sequencer takes the next word from the command
// queue only from idle, while the queue still accepts words until it is full. Each slot
// visit is a read of the slot RAM followed by an id compare or a saturating add and compare.
// A tick also waits on the output port when two expiry words are pending.
// Reset clears the slot valid bits, the command queue and the sequencer; the slot
// RAM itself is not cleared, and no clearing pass runs after reset.
`timescale 1ns / 1ps
`default_nettype none

module named_timer_bank_core #(
  parameter int unsigned NUM_TIMERS = ntb_pkg::NumTimersDefault
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          s_axis_tvalid_i,
  output logic                               s_axis_tready_o,
  // timer_id, count_dir, initial_time, reload_time, goal_time, run_enable,
  // one_shot, delta_time, zero pad
  input  wire logic [ntb_pkg::InDataW-1:0]   s_axis_tdata_i,
  // func
  input  wire logic [ntb_pkg::FuncW-1:0]     s_axis_tuser_i,
  output logic                               m_axis_tvalid_o,
  input  wire logic                          m_axis_tready_i,
  // status, out_id, out_dir, out_current, out_reload, out_goal, out_enable,
  // out_one_shot, zero pad
  output logic [ntb_pkg::OutDataW-1:0]       m_axis_tdata_o,
  // result_kind
  output logic [ntb_pkg::KindW-1:0]          m_axis_tuser_o,
  output logic                               m_axis_tlast_o
);

  logic              cmd_valid;
  ntb_pkg::cmd_t     cmd;
  logic              cmd_pop;
  ntb_pkg::result_t  result;

  ntb_front u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .cmd_valid_o     (cmd_valid),
    .cmd_o           (cmd),
    .cmd_pop_i       (cmd_pop)
  );

  ntb_back #(
    .NUM_TIMERS (NUM_TIMERS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_valid),
    .cmd_i       (cmd),
    .cmd_pop_o   (cmd_pop),
    .m_valid_o   (m_axis_tvalid_o),
    .m_ready_i   (m_axis_tready_i),
    .result_o    (result)
  );

  assign m_axis_tdata_o = {2'b00, result.one, result.en, result.goal, result.reload,
                           result.cur, result.dir, result.id, result.status};
  assign m_axis_tuser_o = result.kind;
  assign m_axis_tlast_o = result.last;

endmodule

`default_nettype wire

>>> rtl/core/ntb_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none

module ntb_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 8
) (
  input  wire logic                                   clk_i,
  input  wire logic                                   we_i,
  input  wire logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] waddr_i,
  input  wire logic [Width-1:0]                       wdata_i,
  input  wire logic                                   re_i,
  input  wire logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] raddr_i,
  output logic      [Width-1:0]                       rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/ntb_front.sv
// Input side: unpacks and classifies words and queues commands for the back end.
`timescale 1ns / 1ps
`default_nettype none

module ntb_front (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          s_axis_tvalid_i,
  output logic                               s_axis_tready_o,
  input  wire logic [ntb_pkg::InDataW-1:0]   s_axis_tdata_i,
  input  wire logic [ntb_pkg::FuncW-1:0]     s_axis_tuser_i,
  output logic                               cmd_valid_o,
  output ntb_pkg::cmd_t                      cmd_o,
  input  wire logic                          cmd_pop_i
);

  ntb_pkg::cmd_t                       cmd_in;
  ntb_pkg::cmd_t                       queue_q [ntb_pkg::QueueDepth];
  logic [ntb_pkg::QueuePtrW-1:0]       wr_ptr_q, wr_ptr_d;
  logic [ntb_pkg::QueuePtrW-1:0]       rd_ptr_q, rd_ptr_d;
  logic [ntb_pkg::QueueCntW-1:0]       cnt_q, cnt_d;
  logic                                known_op;
  logic                                push;
  logic                                pop;

  always_comb begin
    cmd_in.op          = ntb_pkg::func_e'(s_axis_tuser_i);
    cmd_in.id          = s_axis_tdata_i[15:0];
    cmd_in.dir         = s_axis_tdata_i[16];
    cmd_in.init_time   = s_axis_tdata_i[48:17];
    cmd_in.reload_time = s_axis_tdata_i[80:49];
    cmd_in.goal_time   = s_axis_tdata_i[112:81];
    cmd_in.en          = s_axis_tdata_i[113];
    cmd_in.one         = s_axis_tdata_i[114];
    cmd_in.delta       = s_axis_tdata_i[145:115];
  end

  // The unused function code is taken and dropped without a result.
  always_comb begin
    case (cmd_in.op)
      ntb_pkg::FuncAdd:  known_op = 1'b1;
      ntb_pkg::FuncGet:  known_op = 1'b1;
      ntb_pkg::FuncTick: known_op = 1'b1;
      default:           known_op = 1'b0;
    endcase
  end

  assign s_axis_tready_o = (cnt_q != ntb_pkg::QueueCntW'(ntb_pkg::QueueDepth));
  assign push            = s_axis_tvalid_i && s_axis_tready_o && known_op;
  assign cmd_valid_o     = (cnt_q != '0);
  assign pop             = cmd_pop_i && cmd_valid_o;
  assign cmd_o           = queue_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == ntb_pkg::QueuePtrW'(ntb_pkg::QueueDepth - 1)) ?
                 '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == ntb_pkg::QueuePtrW'(ntb_pkg::QueueDepth - 1)) ?
                 '0 : rd_ptr_q + 1'b1;
    end
    if (push && !pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop && !push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      queue_q[wr_ptr_q] <= cmd_in;
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/ntb_back.sv
// Execution side: slot store, slot scan sequencer and the output register.
`timescale 1ns / 1ps
`default_nettype none

module ntb_back #(
  parameter int unsigned NUM_TIMERS = ntb_pkg::NumTimersDefault
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            cmd_valid_i,
  input  wire ntb_pkg::cmd_t   cmd_i,
  output logic                 cmd_pop_o,
  output logic                 m_valid_o,
  input  wire logic            m_ready_i,
  output ntb_pkg::result_t     result_o
);

  localparam int unsigned SlotW = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
  localparam int unsigned SlotDataW = $bits(ntb_pkg::slot_t);
  localparam logic [SlotW-1:0] LastSlot = SlotW'(NUM_TIMERS - 1);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SRD  = 3'd1;
  localparam logic [2:0] S_SEX  = 3'd2;
  localparam logic [2:0] S_RES  = 3'd3;
  localparam logic [2:0] S_TRD  = 3'd4;
  localparam logic [2:0] S_TEX  = 3'd5;
  localparam logic [2:0] S_TFIN = 3'd6;

  logic [2:0]               state_q, state_d;
  logic [SlotW-1:0]         idx_q, idx_d;
  ntb_pkg::cmd_t            cmd_q, cmd_d;
  logic                     found_q, found_d;
  logic                     free_found_q, free_found_d;
  logic [SlotW-1:0]         free_idx_q, free_idx_d;
  ntb_pkg::slot_t           hit_q, hit_d;
  logic [NUM_TIMERS-1:0]    valid_q, valid_d;
  logic                     pend_q, pend_d;
  logic [ntb_pkg::IdW-1:0]  pend_id_q, pend_id_d;
  logic                     out_valid_q, out_valid_d;
  ntb_pkg::result_t         out_q, out_d;

  logic                     ram_we, ram_re;
  logic [SlotW-1:0]         ram_waddr;
  ntb_pkg::slot_t           ram_wdata, rd_slot, new_slot, upd_slot;
  logic [SlotDataW-1:0]     ram_rdata;

  logic                     out_free;
  logic [ntb_pkg::TimeW:0]  up_sum, dn_diff;
  logic signed [ntb_pkg::TimeW-1:0] next_cur;
  logic                     tick_hit;
  logic                     active;

  ntb_ram #(
    .Width (SlotDataW),
    .Depth (NUM_TIMERS)
  ) u_slot_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (idx_q),
    .rdata_o (ram_rdata)
  );

  assign rd_slot  = ntb_pkg::slot_t'(ram_rdata);
  assign out_free = !out_valid_q || m_ready_i;
  assign active   = valid_q[idx_q] && rd_slot.en;

  // One saturating add or subtract, chosen by direction, and one goal compare per visited slot.
  always_comb begin
    up_sum  = {rd_slot.cur[ntb_pkg::TimeW-1], rd_slot.cur} +
              {2'b00, cmd_q.delta};
    dn_diff = {rd_slot.cur[ntb_pkg::TimeW-1], rd_slot.cur} -
              {2'b00, cmd_q.delta};
    if (rd_slot.dir) begin
      next_cur = (dn_diff[ntb_pkg::TimeW] != dn_diff[ntb_pkg::TimeW-1]) ?
                 32'sh8000_0000 : $signed(dn_diff[ntb_pkg::TimeW-1:0]);
      tick_hit = (next_cur <= $signed(rd_slot.goal));
    end else begin
      next_cur = (up_sum[ntb_pkg::TimeW] != up_sum[ntb_pkg::TimeW-1]) ?
                 32'sh7FFF_FFFF : $signed(up_sum[ntb_pkg::TimeW-1:0]);
      tick_hit = (next_cur >= $signed(rd_slot.goal));
    end
    upd_slot     = rd_slot;
    upd_slot.cur = tick_hit ? rd_slot.reload : next_cur;
  end

  always_comb begin
    new_slot.id     = cmd_q.id;
    new_slot.dir    = cmd_q.dir;
    new_slot.en     = cmd_q.en;
    new_slot.one    = cmd_q.one;
    new_slot.cur    = cmd_q.init_time;
    new_slot.reload = cmd_q.reload_time;
    new_slot.goal   = cmd_q.goal_time;
  end

  always_comb begin
    state_d      = state_q;
    idx_d        = idx_q;
    cmd_d        = cmd_q;
    found_d      = found_q;
    free_found_d = free_found_q;
    free_idx_d   = free_idx_q;
    hit_d        = hit_q;
    valid_d      = valid_q;
    pend_d       = pend_q;
    pend_id_d    = pend_id_q;
    out_valid_d  = out_valid_q;
    out_d        = out_q;
    ram_we       = 1'b0;
    ram_re       = 1'b0;
    ram_waddr    = idx_q;
    ram_wdata    = upd_slot;
    cmd_pop_o    = 1'b0;

    if (out_valid_q && m_ready_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        if (cmd_valid_i) begin
          cmd_pop_o    = 1'b1;
          cmd_d        = cmd_i;
          idx_d        = '0;
          found_d      = 1'b0;
          free_found_d = 1'b0;
          pend_d       = 1'b0;
          state_d      = (cmd_i.op == ntb_pkg::FuncTick) ? S_TRD : S_SRD;
        end
      end
      S_SRD: begin
        ram_re  = 1'b1;
        state_d = S_SEX;
      end
      S_SEX: begin
        if (valid_q[idx_q] && (rd_slot.id == cmd_q.id)) begin
          found_d = 1'b1;
          hit_d   = rd_slot;
          state_d = S_RES;
        end else begin
          if (!valid_q[idx_q] && !free_found_q) begin
            free_found_d = 1'b1;
            free_idx_d   = idx_q;
          end
          if (idx_q == LastSlot) begin
            state_d = S_RES;
          end else begin
            idx_d   = idx_q + 1'b1;
            state_d = S_SRD;
          end
        end
      end
      S_RES: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_d       = '0;
          out_d.id    = cmd_q.id;
          out_d.last  = 1'b1;
          if (cmd_q.op == ntb_pkg::FuncAdd) begin
            out_d.kind = ntb_pkg::KindAdd;
            if (found_q) begin
              out_d.status = ntb_pkg::StDup;
            end else if (free_found_q) begin
              out_d.status        = ntb_pkg::StAdded;
              ram_we              = 1'b1;
              ram_waddr           = free_idx_q;
              ram_wdata           = new_slot;
              valid_d[free_idx_q] = 1'b1;
            end else begin
              out_d.status = ntb_pkg::StFull;
            end
          end else begin
            out_d.kind = ntb_pkg::KindGet;
            if (found_q) begin
              out_d.status = ntb_pkg::StFound;
              out_d.dir    = hit_q.dir;
              out_d.cur    = hit_q.cur;
              out_d.reload = hit_q.reload;
              out_d.goal   = hit_q.goal;
              out_d.en     = hit_q.en;
              out_d.one    = hit_q.one;
            end else begin
              out_d.status = ntb_pkg::StNotFound;
            end
          end
          state_d = S_IDLE;
        end
      end
      S_TRD: begin
        ram_re  = 1'b1;
        state_d = S_TEX;
      end
      S_TEX: begin
        // An expiry is held back one event so that the final one can carry last.
        if (!(active && tick_hit && pend_q && !out_free)) begin
          if (active) begin
            ram_we = 1'b1;
            if (tick_hit) begin
              if (pend_q) begin
                out_valid_d = 1'b1;
                out_d       = '0;
                out_d.kind  = ntb_pkg::KindExpiry;
                out_d.id    = pend_id_q;
              end
              pend_d    = 1'b1;
              pend_id_d = rd_slot.id;
              if (rd_slot.one) begin
                valid_d[idx_q] = 1'b0;
              end
            end
          end
          if (idx_q == LastSlot) begin
            state_d = S_TFIN;
          end else begin
            idx_d   = idx_q + 1'b1;
            state_d = S_TRD;
          end
        end
      end
      S_TFIN: begin
        if (!pend_q) begin
          state_d = S_IDLE;
        end else if (out_free) begin
          out_valid_d = 1'b1;
          out_d       = '0;
          out_d.kind  = ntb_pkg::KindExpiry;
          out_d.id    = pend_id_q;
          out_d.last  = 1'b1;
          pend_d      = 1'b0;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      valid_q     <= '0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      valid_q     <= valid_d;
      pend_q      <= pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q        <= idx_d;
    cmd_q        <= cmd_d;
    found_q      <= found_d;
    free_found_q <= free_found_d;
    free_idx_q   <= free_idx_d;
    hit_q        <= hit_d;
    pend_id_q    <= pend_id_d;
    out_q        <= out_d;
  end

  assign m_valid_o = out_valid_q;
  assign result_o  = out_q;

endmodule

`default_nettype wire

>>> rtl/core/ntb_checker.sv
// Port-level checks on the timer bank's output stream, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module ntb_checker (
  input wire logic                          clk_i,
  input wire logic                          rst_ni,
  input wire logic                          m_axis_tvalid_o,
  input wire logic                          m_axis_tready_i,
  input wire logic [ntb_pkg::OutDataW-1:0]  m_axis_tdata_o,
  input wire logic [ntb_pkg::KindW-1:0]     m_axis_tuser_o,
  input wire logic                          m_axis_tlast_o
);

  // A stalled word keeps its valid and its payload.
  `ASSERT_CLKD(a_out_hold, clk_i, rst_ni,
    m_axis_tvalid_o && !m_axis_tready_i |=>
      m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tuser_o) &&
      $stable(m_axis_tlast_o))

  // Nothing is offered in the cycle after reset was active.
  `ASSERT_ALWAYS(a_reset_idle, clk_i, !rst_ni |=> !m_axis_tvalid_o)

  // An add status or a get reply is always the only word of its command.
  `ASSERT_CLKD(a_reply_last, clk_i, rst_ni,
    m_axis_tvalid_o && (m_axis_tuser_o == ntb_pkg::KindAdd ||
      m_axis_tuser_o == ntb_pkg::KindGet) |-> m_axis_tlast_o)

  // An expiry word carries only a name: zero status and zero timer fields.
  `ASSERT_CLKD(a_expiry_clean, clk_i, rst_ni,
    m_axis_tvalid_o && m_axis_tuser_o == ntb_pkg::KindExpiry |->
      m_axis_tdata_o[2:0] == 3'd0 && m_axis_tdata_o[119:19] == '0)

endmodule

bind named_timer_bank_core ntb_checker u_ntb_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o),
  .m_axis_tuser_o  (m_axis_tuser_o),
  .m_axis_tlast_o  (m_axis_tlast_o)
);

`default_nettype wire

>>> dv/ntb_bank_monitor.sv
// Stream monitor for the named timer bank: predicts every result word and compares it.
`timescale 1ns / 1ps

module ntb_bank_monitor #(
  parameter int unsigned NUM_TIMERS = ntb_pkg::NumTimersDefault
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          s_axis_tvalid_i,
  input  wire logic                          s_axis_tready_i,
  // timer_id, count_dir, initial_time, reload_time, goal_time, run_enable,
  // one_shot, delta_time, zero pad
  input  wire logic [ntb_pkg::InDataW-1:0]   s_axis_tdata_i,
  // func
  input  wire logic [ntb_pkg::FuncW-1:0]     s_axis_tuser_i,
  input  wire logic                          m_axis_tvalid_i,
  input  wire logic                          m_axis_tready_i,
  // status, out_id, out_dir, out_current, out_reload, out_goal, out_enable,
  // out_one_shot, zero pad
  input  wire logic [ntb_pkg::OutDataW-1:0]  m_axis_tdata_i,
  // result_kind
  input  wire logic [ntb_pkg::KindW-1:0]     m_axis_tuser_i,
  input  wire logic                          m_axis_tlast_i,
  output int unsigned                        fail_count_o,
  output int unsigned                        pending_o
);
  import ntb_pkg::*;

  localparam logic signed [TimeW+1:0] TimeCeil  = 34'sh0_7FFF_FFFF;
  localparam logic signed [TimeW+1:0] TimeFloor = -34'sh0_8000_0000;

  logic        bank_live [NUM_TIMERS];
  slot_t       bank [NUM_TIMERS];
  result_t     expected_words [$];
  int unsigned mismatches = 0;

  assign fail_count_o = mismatches;

  task automatic compare_field(input string label, input logic [TimeW-1:0] want,
                               input logic [TimeW-1:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, label, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : track
    int                      found_at;
    int                      free_at;
    logic                    have_held;
    logic                    hit;
    result_t                 word;
    result_t                 held;
    slot_t                   entry;
    logic [IdW-1:0]          name;
    logic [DeltaW-1:0]       delta;
    logic signed [TimeW+1:0] moved;
    logic signed [TimeW+1:0] target;
    if (!rst_ni) begin
      for (int i = 0; i < NUM_TIMERS; i++) bank_live[i] = 1'b0;
      expected_words.delete();
      pending_o <= 0;
    end else begin
      if (m_axis_tvalid_i && m_axis_tready_i) begin
        if (expected_words.size() == 0) begin
          $display("%0t: result word with nothing pending, expected none, actual kind %0d id %h",
                   $time, m_axis_tuser_i, m_axis_tdata_i[18:3]);
          mismatches++;
        end else begin
          word = expected_words.pop_front();
          compare_field("kind", word.kind, m_axis_tuser_i);
          compare_field("status", word.status, m_axis_tdata_i[2:0]);
          compare_field("timer id", word.id, m_axis_tdata_i[18:3]);
          compare_field("direction", word.dir, m_axis_tdata_i[19]);
          compare_field("current", word.cur, m_axis_tdata_i[51:20]);
          compare_field("reload", word.reload, m_axis_tdata_i[83:52]);
          compare_field("goal", word.goal, m_axis_tdata_i[115:84]);
          compare_field("enable", word.en, m_axis_tdata_i[116]);
          compare_field("one-shot", word.one, m_axis_tdata_i[117]);
          compare_field("last", word.last, m_axis_tlast_i);
        end
      end

      if (s_axis_tvalid_i && s_axis_tready_i) begin
        name  = s_axis_tdata_i[15:0];
        delta = s_axis_tdata_i[145:115];
        word = '0;
        word.id = name;
        word.last = 1'b1;
        found_at = -1;
        free_at = -1;
        for (int i = 0; i < NUM_TIMERS; i++) begin
          if (found_at < 0 && bank_live[i] && bank[i].id == name) found_at = i;
          if (free_at < 0 && !bank_live[i]) free_at = i;
        end
        case (s_axis_tuser_i)
          FuncAdd: begin
            word.kind = KindAdd;
            // A duplicate name is reported even when the bank is also full.
            if (found_at >= 0) begin
              word.status = StDup;
            end else if (free_at < 0) begin
              word.status = StFull;
            end else begin
              word.status = StAdded;
              entry.id     = name;
              entry.dir    = s_axis_tdata_i[16];
              entry.cur    = s_axis_tdata_i[48:17];
              entry.reload = s_axis_tdata_i[80:49];
              entry.goal   = s_axis_tdata_i[112:81];
              entry.en     = s_axis_tdata_i[113];
              entry.one    = s_axis_tdata_i[114];
              bank[free_at] = entry;
              bank_live[free_at] = 1'b1;
            end
            expected_words.push_back(word);
          end
          FuncGet: begin
            word.kind = KindGet;
            if (found_at < 0) begin
              word.status = StNotFound;
            end else begin
              entry = bank[found_at];
              word.status = StFound;
              word.dir    = entry.dir;
              word.cur    = entry.cur;
              word.reload = entry.reload;
              word.goal   = entry.goal;
              word.en     = entry.en;
              word.one    = entry.one;
            end
            expected_words.push_back(word);
          end
          FuncTick: begin
            // Each expiry is held back one step so the final one can carry the last flag.
            have_held = 1'b0;
            held = '0;
            for (int i = 0; i < NUM_TIMERS; i++) begin
              if (bank_live[i] && bank[i].en) begin
                entry = bank[i];
                target = $signed({{2{entry.goal[TimeW-1]}}, entry.goal});
                if (entry.dir) begin
                  moved = $signed({{2{entry.cur[TimeW-1]}}, entry.cur}) -
                          $signed({3'b000, delta});
                  if (moved < TimeFloor) moved = TimeFloor;
                  hit = (moved <= target);
                end else begin
                  moved = $signed({{2{entry.cur[TimeW-1]}}, entry.cur}) +
                          $signed({3'b000, delta});
                  if (moved > TimeCeil) moved = TimeCeil;
                  hit = (moved >= target);
                end
                entry.cur = moved[TimeW-1:0];
                if (hit) begin
                  entry.cur = entry.reload;
                  if (have_held) expected_words.push_back(held);
                  held = '0;
                  held.kind = KindExpiry;
                  held.status = StAdded;
                  held.id = entry.id;
                  have_held = 1'b1;
                  if (entry.one) bank_live[i] = 1'b0;
                end
                bank[i] = entry;
              end
            end
            if (have_held) begin
              held.last = 1'b1;
              expected_words.push_back(held);
            end
          end
          default: begin
            // The spare function code is dropped without a reply.
          end
        endcase
      end
      pending_o <= expected_words.size();
    end
  end

endmodule

>>> dv/testbench.sv
// Top of the named timer bank testbench: clock, reset, stimulus, result sink and verdict.
`timescale 1ns / 1ps

module testbench;
  import ntb_pkg::*;

  localparam int unsigned NumTimers    = NumTimersDefault;
  // Code 3 is not an operation; the block must swallow it silently.
  localparam logic [FuncW-1:0] FuncUnused = 2'd3;
  localparam int unsigned PadLsb       = IdW + 1 + 3 * TimeW + 2 + DeltaW;
  localparam int unsigned CycleLimit   = 800000;
  localparam int unsigned DrainCycles  = 4 * NumTimers + 20;
  localparam int unsigned RxHoldCycles = 600;
  localparam int unsigned PoolSize     = 12;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_ready;
  logic [InDataW-1:0]  in_data = '0;
  logic [FuncW-1:0]    in_func = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic [OutDataW-1:0] out_data;
  logic [KindW-1:0]    out_kind;
  logic                out_last;
  int unsigned         fail_count;
  int unsigned         pending_words;
  int unsigned         cycle_count = 0;
  logic                quiet_phase = 1'b0;
  logic                rx_hold_req = 1'b0;
  logic [IdW-1:0]      name_pool [PoolSize];
  // Timers that never free their slot; kept few so the bank keeps turning over.
  int unsigned         permanent_budget = 2;

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  named_timer_bank_core #(
    .NUM_TIMERS(NumTimers)
  ) DUT (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .s_axis_tvalid_i (in_valid),
    .s_axis_tready_o (in_ready),
    .s_axis_tdata_i  (in_data),
    .s_axis_tuser_i  (in_func),
    .m_axis_tvalid_o (out_valid),
    .m_axis_tready_i (out_ready),
    .m_axis_tdata_o  (out_data),
    .m_axis_tuser_o  (out_kind),
    .m_axis_tlast_o  (out_last)
  );

  ntb_bank_monitor #(
    .NUM_TIMERS(NumTimers)
  ) bank_monitor (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .s_axis_tvalid_i (in_valid),
    .s_axis_tready_i (in_ready),
    .s_axis_tdata_i  (in_data),
    .s_axis_tuser_i  (in_func),
    .m_axis_tvalid_i (out_valid),
    .m_axis_tready_i (out_ready),
    .m_axis_tdata_i  (out_data),
    .m_axis_tuser_i  (out_kind),
    .m_axis_tlast_i  (out_last),
    .fail_count_o    (fail_count),
    .pending_o       (pending_words)
  );

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("%0t: run stopped after %0d cycles", $time, CycleLimit);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  function automatic logic [InDataW-1:0] noise_bits();
    logic [159:0] raw;
    raw = {$urandom, $urandom, $urandom, $urandom, $urandom};
    return InDataW'(raw[PadLsb-1:0]);
  endfunction

  function automatic logic [IdW-1:0] pick_name();
    if ($urandom_range(0, 9) == 0) return IdW'($urandom);
    return name_pool[$urandom_range(0, PoolSize - 1)];
  endfunction

  task automatic send_word(input logic [FuncW-1:0] code, input logic [InDataW-1:0] data);
    int unsigned gap;
    gap = quiet_phase ? 0 : $urandom_range(0, 15);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_func <= code;
    in_data <= data;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic issue_add(input logic [IdW-1:0] name, input logic down,
                           input logic [TimeW-1:0] start, input logic [TimeW-1:0] restart,
                           input logic [TimeW-1:0] target, input logic run, input logic once);
    send_word(FuncAdd, InDataW'({DeltaW'($urandom), once, run, target, restart, start,
                                 down, name}));
  endtask

  task automatic issue_get(input logic [IdW-1:0] name);
    logic [InDataW-1:0] data;
    data = noise_bits();
    data[IdW-1:0] = name;
    send_word(FuncGet, data);
  endtask

  task automatic issue_tick(input logic [DeltaW-1:0] delta);
    logic [InDataW-1:0] data;
    data = noise_bits();
    data[PadLsb-1:PadLsb-DeltaW] = delta;
    send_word(FuncTick, data);
  endtask

  task automatic random_add();
    logic           down;
    logic           run;
    logic           once;
    logic [TimeW-1:0] start;
    logic [TimeW-1:0] restart;
    logic [TimeW-1:0] target;
    logic [TimeW-1:0] step;
    int unsigned    kind_pick;
    down = 1'($urandom_range(0, 1));
    run = 1'b1;
    once = 1'b1;
    if (permanent_budget > 0 && $urandom_range(0, 29) == 0) begin
      permanent_budget--;
      kind_pick = $urandom_range(0, 2);
      run = (kind_pick == 0);
      once = (kind_pick == 2);
    end
    if ($urandom_range(0, 9) == 0) begin
      start = $urandom;
      restart = $urandom;
      target = $urandom;
    end else begin
      // Goal a few ticks away on the side the timer moves toward.
      start = $urandom_range(0, 32'h0020_0000) - 32'h0010_0000;
      step = $urandom_range(0, 8000);
      target = down ? start - step : start + step;
      restart = start + $urandom_range(0, 2000) - 32'd1000;
    end
    issue_add(pick_name(), down, start, restart, target, run, once);
  endtask

  initial begin : result_sink
    int unsigned stall;
    wait (rst_n == 1'b1);
    @(posedge clk);
    forever begin
      if (rx_hold_req) begin
        // Long hold so the result path fills and the input side backs up.
        rx_hold_req = 1'b0;
        out_ready <= 1'b0;
        repeat (RxHoldCycles) @(posedge clk);
      end else begin
        stall = quiet_phase ? 0 : $urandom_range(0, 15);
        if (stall > 0) begin
          out_ready <= 1'b0;
          repeat (stall) @(posedge clk);
        end
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
    end
  end

  initial begin : stimulus
    int unsigned      phase;
    int unsigned      done;
    int unsigned      roll;
    int unsigned      tick_share;
    logic [DeltaW-1:0] delta;
    name_pool[0] = 16'hFFFF;
    name_pool[1] = 16'h1234;
    for (int i = 2; i < PoolSize; i++) name_pool[i] = IdW'($urandom);
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    repeat (2) @(posedge clk);

    // Empty bank: lookups miss and ticks stay silent.
    issue_get(16'h0000);
    issue_tick('0);
    send_word(FuncUnused, noise_bits());
    // Extreme names and times, a duplicate, and a disabled timer.
    issue_add(16'hFFFF, 1'b0, 32'h7FFF_0000, 32'h8000_0000, 32'h7FFF_FFFF, 1'b1, 1'b0);
    issue_add(16'h0000, 1'b1, 32'h8001_0000, 32'h7FFF_FFFF, 32'h8000_0000, 1'b1, 1'b1);
    issue_add(16'hFFFF, 1'b1, 32'h0000_0001, 32'h0000_0002, 32'h0000_0003, 1'b0, 1'b1);
    issue_add(16'h1234, 1'b0, 32'h0000_0000, 32'h0000_0005, 32'h0000_0000, 1'b0, 1'b1);
    issue_add(16'h0F0F, 1'b0, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 1'b1, 1'b0);
    issue_get(16'hFFFF);
    issue_get(16'h1234);
    // Full-scale tick saturates both directions; the down one-shot is freed.
    issue_tick(31'h7FFF_FFFF);
    issue_get(16'h0000);
    issue_get(16'hFFFF);
    for (int i = 1; i <= 5; i++) begin
      issue_add(IdW'(i), 1'b0, 32'h0, 32'h0, 32'h1, 1'b1, 1'b1);
    end
    issue_add(16'h0006, 1'b0, 32'h0, 32'h0, 32'h1, 1'b1, 1'b1);
    issue_add(16'h1234, 1'b1, 32'h0, 32'h0, 32'h0, 1'b1, 1'b1);
    issue_tick(31'd1);
    issue_get(16'h0003);
    issue_tick('0);

    for (phase = 0; phase < 9; phase++) begin
      quiet_phase = (phase % 3 == 1);
      tick_share = (phase == 3) ? 60 : 35;
      if (phase == 3) rx_hold_req = 1'b1;
      if (phase == 6) begin
        // Sender pause: let every outstanding word come back first.
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_words != 0) @(posedge clk);
      end
      done = 0;
      while (done < 50) begin
        roll = $urandom_range(0, 99);
        if (roll < 4) begin
          send_word(FuncUnused, noise_bits());
        end else begin
          done++;
          if (roll < 4 + tick_share) begin
            roll = $urandom_range(0, 99);
            if (roll < 6) delta = DeltaW'($urandom);
            else if (roll < 10) delta = '0;
            else delta = DeltaW'($urandom_range(0, 3000));
            issue_tick(delta);
          end else if (roll < 34 + tick_share) begin
            random_add();
          end else begin
            issue_get(pick_name());
          end
        end
      end
    end

    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_words != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
    if (fail_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
